FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked at every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/sm3c_pkg.sv
`timescale 1ns / 1ps
package sm3c_pkg;

  localparam int LANES = 4;
  localparam int LANE_W = 2;

  localparam logic [31:0] TJ_LOW = 32'h79CC4519;
  localparam logic [31:0] TJ_HIGH = 32'h7A879D8A;

  localparam logic [255:0] SM3_IV = {
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  typedef struct packed {
    logic [1:0]  lane;
    logic [31:0] message_word;
    logic        start_message;
    logic        finish_message;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_lane;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;
  } out_item_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

FILE: hw/rtl/sm3_hash_compress_four_lanes.sv
`timescale 1ns / 1ps
// Four-lane SM3 compression engine.
// Input channel (in_valid/in_ready, in_data): one big-endian message word
// for one lane. Words of a lane are buffered in a shared block memory; the
// start flag reloads the lane's chaining value with the SM3 IV and restarts
// its block. Output channel (out_valid/out_ready, out_data): eight digest
// words, most significant first, the eighth marked by last_word.
// A word that does not end a block is taken and in_ready stays high. A
// 16th word starts a compression: the block is loaded into the message
// window through the registered memory read, the shared round unit runs
// one round per cycle, and the result is folded into the chaining value
// word by word, with in_ready low throughout. With finish set the digest
// words are then read from the chaining value memory and leave one per
// cycle through the output register while the receiver is ready; a
// stalled receiver holds the current word and the block waits with
// in_ready low.
// Reset (rst, synchronous) clears word counts, state and output valid and
// marks every lane's chaining value as IV; the block buffers are not
// cleared and are only read once a full block has been written.
module sm3_hash_compress_four_lanes
  import sm3c_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_FOLD = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state;
  logic [6:0] cnt;
  logic [1:0] cur_lane;
  logic       cur_finish;
  logic [3:0] word_counts [LANES];
  logic [LANES-1:0] cv_is_iv;

  // block memory and chaining values in memories
  logic [31:0] blk_mem [16*LANES];
  logic [31:0] cv_mem [8*LANES];
  logic [31:0] blk_rd;
  logic [31:0] cv_rd;

  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [31:0] fold_hold [8];

  logic accept;
  logic [3:0] wc;
  assign accept = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign wc = in_data.start_message ? 4'd0 : word_counts[in_data.lane];

  // block memory read address: index during load
  logic [5:0] blk_raddr;
  assign blk_raddr = {cur_lane, cnt[3:0]};
  logic [4:0] cv_raddr;
  assign cv_raddr = {cur_lane, cnt[2:0]};

  always_ff @(posedge clk) begin
    if (accept) begin
      blk_mem[{in_data.lane, wc}] <= in_data.message_word;
    end
    blk_rd <= blk_mem[blk_raddr];
  end

  // next-window word from the expansion recurrence
  logic [31:0] w_new;
  assign w_new = perm1(w[0] ^ w[7] ^ rotl(w[13], 5'd15)) ^ rotl(w[3], 5'd7) ^ w[10];

  // round unit
  logic [5:0]  rj;
  logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2;
  assign rj = cnt[5:0];
  always_comb begin
    tj = (rj <= 6'd15) ? TJ_LOW : TJ_HIGH;
    a12 = rotl(a, 5'd12);
    ss1 = rotl(a12 + e + rotl(tj, rj[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (rj <= 6'd15) begin
      ff = a ^ b ^ c;
      gg = e ^ f ^ g;
    end else begin
      ff = (a & b) | (a & c) | (b & c);
      gg = (e & f) | (~e & g);
    end
    tt1 = ff + d + ss2 + (w[0] ^ w[4]);
    tt2 = gg + h + ss1 + w[0];
  end

  // chaining value read: IV when lane reloaded
  logic [31:0] cv_word;
  logic [31:0] iv_word;
  assign iv_word = SM3_IV[(7 - cv_raddr[2:0])*32 +: 32];
  assign cv_word = cv_is_iv[cur_lane] ? iv_word : cv_mem[cv_raddr];

  // fold the result into cv_mem; hold the read word while a digest transaction is stalled
  always_ff @(posedge clk) begin
    if (state == S_FOLD) begin
      cv_mem[cv_raddr] <= cv_word ^ fold_hold[cnt[2:0]];
    end
    if (!(state == S_EMIT && out_valid && !out_ready)) begin
      cv_rd <= cv_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      cv_is_iv <= '1;
      out_valid <= 1'b0;
      for (int i = 0; i < LANES; i++) word_counts[i] <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_data.start_message) cv_is_iv[in_data.lane] <= 1'b1;
            cur_lane <= in_data.lane;
            cur_finish <= in_data.finish_message;
            if (wc == 4'd15) begin
              word_counts[in_data.lane] <= '0;
              state <= S_LOAD;
              cnt <= 7'd0;
            end else begin
              word_counts[in_data.lane] <= wc + 4'd1;
            end
          end
        end
        // shift block into window from the registered read; also load a..h
        S_LOAD: begin
          if (cnt != 7'd0) begin
            for (int i = 0; i < 15; i++) w[i] <= w[i+1];
            w[15] <= blk_rd;
          end
          if (cnt >= 7'd1 && cnt <= 7'd8) begin
            {a, b, c, d, e, f, g, h} <= {b, c, d, e, f, g, h, cv_rd};
          end
          if (cnt == 7'd16) begin
            state <= S_ROUND;
            cnt <= '0;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        // one round per cycle, window slides one word
        S_ROUND: begin
          d <= c; c <= rotl(b, 5'd9); b <= a; a <= tt1;
          h <= g; g <= rotl(f, 5'd19); f <= e; e <= perm0(tt2);
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_new;
          if (cnt == 7'd63) begin
            state <= S_FOLD;
            cnt <= '0;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        // write cv ^ state back word by word
        S_FOLD: begin
          if (cnt == 7'd7) begin
            cv_is_iv[cur_lane] <= 1'b0;
            cnt <= '0;
            state <= cur_finish ? S_EMIT : S_IDLE;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        // emit digest from memory through the output register
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            if (out_valid && out_data.last_word) begin
              out_valid <= 1'b0;
              state <= S_IDLE;
              cnt <= '0;
            end else if (cnt != 7'd9) begin
              // cnt 0..7 issues read; data arrives next cycle
              cnt <= cnt + 7'd1;
              out_valid <= (cnt != 7'd0);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // fold snapshot of final working state
  always_ff @(posedge clk) begin
    if (state == S_ROUND && cnt == 7'd63) begin
      fold_hold[0] <= tt1; fold_hold[1] <= a; fold_hold[2] <= rotl(b, 5'd9);
      fold_hold[3] <= c; fold_hold[4] <= perm0(tt2); fold_hold[5] <= e;
      fold_hold[6] <= rotl(f, 5'd19); fold_hold[7] <= g;
    end
  end

  // output payload: word index is cnt-1 when loaded
  always_ff @(posedge clk) begin
    if (state == S_EMIT && (!out_valid || out_ready) && cnt != 7'd0 && cnt <= 7'd8) begin
      out_data.out_lane <= cur_lane;
      out_data.digest_word <= cv_rd;
      out_data.word_number <= 3'(cnt - 7'd1);
      out_data.last_word <= (cnt == 7'd8);
    end
  end

  `include "assert_macros.svh"

  `ASSERT_IMPL(a_no_accept_busy, clk, rst, (state != S_IDLE) |-> !in_ready, "input accepted while busy")
  `ASSERT_IMPL(a_out_only_emit, clk, rst, out_valid |-> (state == S_EMIT), "output valid outside emit")
  `ASSERT_ALWAYS(a_reset_quiet, clk, $past(rst) |-> !out_valid, "output valid after reset")

endmodule

FILE: tb/sm3_hash_compress_four_lanes_tb.sv
`timescale 1ns / 1ps
module sm3_hash_compress_four_lanes_tb;
  import sm3c_pkg::*;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // Digest model state, one set per lane
  logic [31:0] lane_cv [LANES][8];
  logic [31:0] lane_blk [LANES][16];
  logic [3:0]  lane_cnt [LANES];

  out_item_t digest_queue[$];
  int        mismatch_count;
  int        out_stall_max;

  sm3_hash_compress_four_lanes i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [31:0] rol32(logic [31:0] x, int n);
    int k;
    k = n % 32;
    if (k == 0) return x;
    return (x << k) | (x >> (32 - k));
  endfunction

  function automatic logic [31:0] p0f(logic [31:0] x);
    return x ^ rol32(x, 9) ^ rol32(x, 17);
  endfunction

  function automatic logic [31:0] p1f(logic [31:0] x);
    return x ^ rol32(x, 15) ^ rol32(x, 23);
  endfunction

  // Expand the lane's block, run 64 rounds, fold into the chaining value
  task automatic compress_block(int ln);
    logic [31:0] w [68];
    logic [31:0] a, b, c, d, e, f, g, h, a12, tj, ss1, ss2, ff, gg, tt1, tt2;
    for (int j = 0; j < 16; j++) w[j] = lane_blk[ln][j];
    for (int j = 16; j < 68; j++)
      w[j] = p1f(w[j-16] ^ w[j-9] ^ rol32(w[j-3], 15)) ^ rol32(w[j-13], 7) ^ w[j-6];
    a = lane_cv[ln][0]; b = lane_cv[ln][1]; c = lane_cv[ln][2]; d = lane_cv[ln][3];
    e = lane_cv[ln][4]; f = lane_cv[ln][5]; g = lane_cv[ln][6]; h = lane_cv[ln][7];
    for (int j = 0; j < 64; j++) begin
      a12 = rol32(a, 12);
      tj = (j <= 15) ? 32'h79CC4519 : 32'h7A879D8A;
      ss1 = rol32(a12 + e + rol32(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j <= 15) begin
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        ff = (a & b) | (a & c) | (b & c);
        gg = (e & f) | (~e & g);
      end
      tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + h + ss1 + w[j];
      d = c; c = rol32(b, 9); b = a; a = tt1;
      h = g; g = rol32(f, 19); f = e; e = p0f(tt2);
    end
    lane_cv[ln][0] ^= a; lane_cv[ln][1] ^= b; lane_cv[ln][2] ^= c; lane_cv[ln][3] ^= d;
    lane_cv[ln][4] ^= e; lane_cv[ln][5] ^= f; lane_cv[ln][6] ^= g; lane_cv[ln][7] ^= h;
  endtask

  task automatic load_iv(int ln);
    for (int k = 0; k < 8; k++) lane_cv[ln][k] = SM3_IV[255 - 32*k -: 32];
  endtask

  // Advance the model by one accepted word and queue any digest
  task automatic predict_word(in_item_t it);
    int ln;
    int cnt;
    out_item_t r;
    ln = it.lane;
    if (ln >= LANES) return;
    if (it.start_message) begin
      load_iv(ln);
      lane_cnt[ln] = 4'd0;
    end
    cnt = lane_cnt[ln];
    lane_blk[ln][cnt] = it.message_word;
    if (cnt != 15) begin
      lane_cnt[ln] = 4'(cnt + 1);
      return;
    end
    lane_cnt[ln] = 4'd0;
    compress_block(ln);
    if (!it.finish_message) return;
    for (int k = 0; k < 8; k++) begin
      r.out_lane = ln[1:0];
      r.digest_word = lane_cv[ln][k];
      r.word_number = k[2:0];
      r.last_word = (k == 7);
      digest_queue.push_back(r);
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Hold each word until accepted, after a random gap
  task automatic send_word(logic [1:0] ln, logic [31:0] wd, logic st, logic fin);
    int gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{lane: ln, message_word: wd, start_message: st, finish_message: fin};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(in_data);
  endtask

  task automatic send_block(logic [1:0] ln, bit st, bit fin, bit rnd, logic [31:0] fill);
    for (int i = 0; i < 16; i++)
      send_word(ln, rnd ? $urandom() : fill, st && i == 0, fin && i == 15);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (digest_queue.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Check each transaction against the oldest expected digest word
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (digest_queue.size() == 0) begin
        report_mismatch("unexpected transaction", out_data.digest_word, 32'h0);
      end else begin
        want = digest_queue.pop_front();
        if (out_data.out_lane !== want.out_lane)
          report_mismatch("out_lane", 32'(out_data.out_lane), 32'(want.out_lane));
        if (out_data.digest_word !== want.digest_word)
          report_mismatch("digest_word", out_data.digest_word, want.digest_word);
        if (out_data.word_number !== want.word_number)
          report_mismatch("word_number", 32'(out_data.word_number), 32'(want.word_number));
        if (out_data.last_word !== want.last_word)
          report_mismatch("last_word", 32'(out_data.last_word), 32'(want.last_word));
      end
    end
  end

  // Receiver stall per transaction
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  // Standard "abc" block on lane 0 and an all-ones block on lane 3
  task automatic test_directed();
    send_word(2'd0, 32'h61626380, 1'b1, 1'b0);
    for (int i = 1; i < 15; i++) send_word(2'd0, 32'h0, 1'b0, 1'b0);
    send_word(2'd0, 32'h00000018, 1'b0, 1'b1);
    send_block(2'd3, 1'b1, 1'b1, 1'b0, 32'hFFFFFFFF);
    wait_drained();
  endtask

  // Start mid-block, finish off a 16th word, multi-block messages
  task automatic test_special_cases();
    send_word(2'd1, 32'h12345678, 1'b1, 1'b1);
    send_word(2'd1, 32'h9ABCDEF0, 1'b0, 1'b0);
    send_block(2'd1, 1'b1, 1'b0, 1'b1, 32'h0);
    send_block(2'd1, 1'b0, 1'b1, 1'b1, 32'h0);
    send_block(2'd2, 1'b0, 1'b1, 1'b1, 32'h0);
  endtask

  // Interleave lanes with random content, mostly well-formed messages
  task automatic test_random_lanes();
    int blk_no [LANES];
    int ln;
    for (int i = 0; i < LANES; i++) blk_no[i] = 0;
    for (int n = 0; n < 180; n++) begin
      ln = $urandom_range(0, LANES - 1);
      if (n == 90) begin
        // hold off the sender until every digest has come
        wait_drained();
        out_stall_max = 0;
      end
      if (n == 140) out_stall_max = 11;
      if ($urandom_range(0, 19) == 0) begin
        send_word(ln[1:0], $urandom(), 1'b1, 1'($urandom_range(0, 1)));
        blk_no[ln] = 1;
      end else begin
        send_word(ln[1:0], $urandom(), lane_cnt[ln] == 0 && blk_no[ln] == 0,
                  lane_cnt[ln] == 15 && $urandom_range(0, 1));
        blk_no[ln] = (lane_cnt[ln] == 0 && digest_queue.size() != 0) ? 0 : 1;
        if ($urandom_range(0, 7) == 0) blk_no[ln] = 0;
      end
    end
  endtask

  initial begin
    int guard;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    mismatch_count = 0;
    out_stall_max = 11;
    for (int i = 0; i < LANES; i++) begin
      load_iv(i);
      lane_cnt[i] = 4'd0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_special_cases();
    test_random_lanes();
    // Finish every lane so each partial block completes
    for (int i = 0; i < LANES; i++)
      while (lane_cnt[i] != 0)
        send_word(i[1:0], $urandom(), 1'b0, lane_cnt[i] == 15);
    in_valid <= 1'b0;
    guard = 0;
    while (digest_queue.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && digest_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
